### rtl/core/periodic_image_box_overlap_defines.svh
// ----------------------------------------------------------------------------
// Periodic image box overlap assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_IMAGE_BOX_OVERLAP_DEFINES_SVH
`define PERIODIC_IMAGE_BOX_OVERLAP_DEFINES_SVH

// Same-cycle implication.
`define PIBO_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIBO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pibo_pkg.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap package
// Shared widths, register codes, configuration type and image ordering helpers.
// ----------------------------------------------------------------------------
package pibo_pkg;

  localparam int NUM_AXES      = 3;
  localparam int NUM_IMAGES    = 26;
  localparam int LEN_BITS      = 23;
  localparam int SHIFT_BITS    = 24;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [REG_IDX_BITS-1:0] REG_PERIODIC_X = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PERIODIC_Y = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_PERIODIC_Z = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_LEN_X      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_LEN_Y      = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_LEN_Z      = 3'd5;

  // One bit per candidate image, bit 0 first in x-outer, z-inner order.
  typedef logic [NUM_IMAGES-1:0] mask_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]               periodic;
    logic [NUM_AXES-1:0][LEN_BITS-1:0] len;
  } cfg_t;

  // Shift digit (0: minus, 1: none, 2: plus) of image n on one axis. The
  // all-zero shift sits in the middle of the 27 combinations and is skipped.
  function automatic logic [1:0] img_digit(input int n, input int axis);
    int d;
    d = (n < NUM_IMAGES / 2) ? n : n + 1;
    case (axis)
      0:       return 2'(d / 9);
      1:       return 2'((d / 3) % 3);
      default: return 2'(d % 3);
    endcase
  endfunction

  // Images whose shift on the given axis has the given digit.
  function automatic mask_t digit_mask(input int axis, input logic [1:0] dig);
    mask_t m;
    m = '0;
    for (int n = 0; n < NUM_IMAGES; n++) begin
      m[n] = (img_digit(n, axis) == dig);
    end
    return m;
  endfunction

endpackage

### rtl/core/pibo_item_if.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap input channel
// Valid/ready channel carrying one target box and one source box.
// ----------------------------------------------------------------------------
interface pibo_item_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] target_lo_x;
  logic signed [COORD_BITS-1:0] target_lo_y;
  logic signed [COORD_BITS-1:0] target_lo_z;
  logic signed [COORD_BITS-1:0] target_hi_x;
  logic signed [COORD_BITS-1:0] target_hi_y;
  logic signed [COORD_BITS-1:0] target_hi_z;
  logic signed [COORD_BITS-1:0] source_lo_x;
  logic signed [COORD_BITS-1:0] source_lo_y;
  logic signed [COORD_BITS-1:0] source_lo_z;
  logic signed [COORD_BITS-1:0] source_hi_x;
  logic signed [COORD_BITS-1:0] source_hi_y;
  logic signed [COORD_BITS-1:0] source_hi_z;

  modport source (
    output valid, target_lo_x, target_lo_y, target_lo_z,
           target_hi_x, target_hi_y, target_hi_z,
           source_lo_x, source_lo_y, source_lo_z,
           source_hi_x, source_hi_y, source_hi_z,
    input  ready
  );

  modport sink (
    input  valid, target_lo_x, target_lo_y, target_lo_z,
           target_hi_x, target_hi_y, target_hi_z,
           source_lo_x, source_lo_y, source_lo_z,
           source_hi_x, source_hi_y, source_hi_z,
    output ready
  );
endinterface

### rtl/core/pibo_result_if.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap result channel
// Valid/ready channel carrying one overlapping shift per transaction.
// ----------------------------------------------------------------------------
interface pibo_result_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    found;
  logic signed [pibo_pkg::SHIFT_BITS-1:0]  shift_x;
  logic signed [pibo_pkg::SHIFT_BITS-1:0]  shift_y;
  logic signed [pibo_pkg::SHIFT_BITS-1:0]  shift_z;
  logic                                    last;

  modport source (
    output valid, found, shift_x, shift_y, shift_z, last,
    input  ready
  );

  modport sink (
    input  valid, found, shift_x, shift_y, shift_z, last,
    output ready
  );
endinterface

### rtl/core/pibo_fifo.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap hit queue
// Small flip-flop FIFO of image hit masks between the front and back ends.
// ----------------------------------------------------------------------------
`include "periodic_image_box_overlap_defines.svh"

module pibo_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pibo_pkg::mask_t push_mask_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output pibo_pkg::mask_t pop_mask_o
);

  localparam int DEPTH    = pibo_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  pibo_pkg::mask_t     mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_q, rd_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CNT_BITS'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_mask_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign cnt_d        = cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_mask_i;
    end
  end

  `PIBO_ASSERT(a_fifo_count_bound, 1'b1, cnt_q <= CNT_BITS'(DEPTH), "hit queue count overran")

endmodule

### rtl/core/pibo_front.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap front end
// Registers a box pair and tests all images in parallel into a hit mask.
// ----------------------------------------------------------------------------
module pibo_front #(
  parameter int DIMENSIONS = 3,
  parameter int COORD_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pibo_item_if.sink       in_i,
  input  pibo_pkg::cfg_t  cfg_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output pibo_pkg::mask_t push_mask_o
);

  localparam int NA       = pibo_pkg::NUM_AXES;
  localparam int CMP_BITS = ((COORD_BITS > pibo_pkg::LEN_BITS) ?
                             COORD_BITS : pibo_pkg::LEN_BITS) + 2;
  localparam int EXT_BITS = CMP_BITS - COORD_BITS;
  localparam int LEN_EXT  = CMP_BITS - pibo_pkg::LEN_BITS;

  logic                         vld_q;
  logic signed [COORD_BITS-1:0] tlo_q [NA];
  logic signed [COORD_BITS-1:0] thi_q [NA];
  logic signed [COORD_BITS-1:0] slo_q [NA];
  logic signed [COORD_BITS-1:0] shi_q [NA];
  logic                         accept;

  logic signed [CMP_BITS-1:0] t_lo [NA];
  logic signed [CMP_BITS-1:0] t_hi [NA];
  logic signed [CMP_BITS-1:0] s_lo [NA];
  logic signed [CMP_BITS-1:0] s_hi [NA];
  logic signed [CMP_BITS-1:0] len  [NA];
  logic [NA-1:0]              base_ok;
  logic [2:0]                 hit  [NA];

  assign in_i.ready   = !vld_q || push_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign push_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tlo_q[0] <= in_i.target_lo_x;
      tlo_q[1] <= in_i.target_lo_y;
      tlo_q[2] <= in_i.target_lo_z;
      thi_q[0] <= in_i.target_hi_x;
      thi_q[1] <= in_i.target_hi_y;
      thi_q[2] <= in_i.target_hi_z;
      slo_q[0] <= in_i.source_lo_x;
      slo_q[1] <= in_i.source_lo_y;
      slo_q[2] <= in_i.source_lo_z;
      shi_q[0] <= in_i.source_hi_x;
      shi_q[1] <= in_i.source_hi_y;
      shi_q[2] <= in_i.source_hi_z;
    end
  end

  // Per axis, bit 0 is the minus image, bit 1 no shift, bit 2 the plus image.
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      t_lo[a] = {{EXT_BITS{tlo_q[a][COORD_BITS-1]}}, tlo_q[a]};
      t_hi[a] = {{EXT_BITS{thi_q[a][COORD_BITS-1]}}, thi_q[a]};
      s_lo[a] = {{EXT_BITS{slo_q[a][COORD_BITS-1]}}, slo_q[a]};
      s_hi[a] = {{EXT_BITS{shi_q[a][COORD_BITS-1]}}, shi_q[a]};
      len[a]  = {{LEN_EXT{1'b0}}, cfg_i.len[a]};
      base_ok[a] = (t_lo[a] <= t_hi[a]) && (s_lo[a] <= s_hi[a]);
      if (a < DIMENSIONS) begin
        hit[a][0] = cfg_i.periodic[a] && base_ok[a] &&
                    (t_lo[a] <= s_hi[a] - len[a]) && (s_lo[a] - len[a] <= t_hi[a]);
        hit[a][1] = base_ok[a] && (t_lo[a] <= s_hi[a]) && (s_lo[a] <= t_hi[a]);
        hit[a][2] = cfg_i.periodic[a] && base_ok[a] &&
                    (t_lo[a] <= s_hi[a] + len[a]) && (s_lo[a] + len[a] <= t_hi[a]);
      end else begin
        hit[a] = 3'b010;
      end
    end
  end

  always_comb begin
    for (int n = 0; n < pibo_pkg::NUM_IMAGES; n++) begin
      push_mask_o[n] = hit[0][pibo_pkg::img_digit(n, 0)] &
                       hit[1][pibo_pkg::img_digit(n, 1)] &
                       hit[2][pibo_pkg::img_digit(n, 2)];
    end
  end

endmodule

### rtl/core/pibo_back.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap back end
// Walks a hit mask in loop order and issues one shift per transaction.
// ----------------------------------------------------------------------------
`include "periodic_image_box_overlap_defines.svh"

module pibo_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pibo_pkg::cfg_t  cfg_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  pibo_pkg::mask_t pop_mask_i,
  pibo_result_if.source   out_o
);

  localparam int NA = pibo_pkg::NUM_AXES;
  localparam int SB = pibo_pkg::SHIFT_BITS;

  logic                 busy_q, busy_d;
  pibo_pkg::mask_t      cur_q, cur_d;
  logic                 out_vld_q, out_vld_d;
  logic                 found_q;
  logic                 last_q;
  logic signed [SB-1:0] shift_q [NA];
  logic signed [SB-1:0] shift_d [NA];

  pibo_pkg::mask_t      pick, rem;
  logic                 adv, emit, fin, load;
  logic signed [SB-1:0] len_ext [NA];

  assign adv  = !out_vld_q || out_o.ready;
  assign emit = busy_q && adv;
  assign pick = cur_q & (~cur_q + pibo_pkg::NUM_IMAGES'(1));
  assign rem  = cur_q & ~pick;
  assign fin  = emit && (rem == '0);

  assign pop_ready_o = !busy_q || fin;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      len_ext[a] = {{(SB - pibo_pkg::LEN_BITS){1'b0}}, cfg_i.len[a]};
      if (|(pick & pibo_pkg::digit_mask(a, 2'd2))) begin
        shift_d[a] = len_ext[a];
      end else if (|(pick & pibo_pkg::digit_mask(a, 2'd0))) begin
        shift_d[a] = -len_ext[a];
      end else begin
        shift_d[a] = '0;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    if (load) begin
      busy_d = 1'b1;
      cur_d  = pop_mask_i;
    end else if (emit) begin
      busy_d = !fin;
      cur_d  = rem;
    end
    out_vld_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cur_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cur_q     <= cur_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= (cur_q != '0);
      last_q  <= (rem == '0);
      for (int a = 0; a < NA; a++) begin
        shift_q[a] <= shift_d[a];
      end
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.found   = found_q;
  assign out_o.last    = last_q;
  assign out_o.shift_x = shift_q[0];
  assign out_o.shift_y = shift_q[1];
  assign out_o.shift_z = shift_q[2];

  `PIBO_ASSERT_NEXT(a_empty_mask_lone_last, emit && (cur_q == '0), out_vld_q && !found_q && last_q, "empty mask did not give a lone last miss")
  `PIBO_ASSERT(a_miss_is_last, out_vld_q && !found_q, last_q, "miss transaction without last")
  `PIBO_ASSERT_NEXT(a_busy_until_last, emit && (rem != '0), busy_q, "back end went idle before last shift")

endmodule

### rtl/core/periodic_image_box_overlap.sv
// ----------------------------------------------------------------------------
// Periodic image box overlap
// Lists the periodic images of a source box that overlap a target box.
// ----------------------------------------------------------------------------
// Usage: each in_i transaction carries a target box and a source box as
// inclusive signed corners. For it, out_o delivers one transaction per
// overlapping image shift (x outermost, then y, then z), the final one with
// last set; when no image overlaps, a single transaction has found clear,
// zero shifts and last set. Periodicity and domain lengths come from the APB
// registers; they are to be written only while the block is idle, which the
// block itself does not enforce. A box passes the front end input register,
// the hit queue, the back end mask register and the result register, which
// issues one shift per cycle while out_o.ready is high; that drain, not the
// parallel compare front end, sets the sustained rate. A four-entry hit queue
// lets the front end keep taking boxes while the back end drains.
// Reset: all axes non-periodic, domain lengths one, no transaction in flight.
// Stall: when out_o.ready is low the result register holds, the back end
// stops, the queue fills and then in_i.ready drops.
// ----------------------------------------------------------------------------
module periodic_image_box_overlap #(
  parameter int DIMENSIONS = 3,
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pibo_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [pibo_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [pibo_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  pibo_item_if.sink                            in_i,
  pibo_result_if.source                        out_o
);

  localparam int DW = pibo_pkg::APB_DATA_BITS;
  localparam int LB = pibo_pkg::LEN_BITS;

  pibo_pkg::cfg_t                      cfg_q;
  logic [pibo_pkg::REG_IDX_BITS-1:0]   reg_idx;
  logic                                cfg_we;

  logic            push_valid, push_ready;
  pibo_pkg::mask_t push_mask;
  logic            pop_valid, pop_ready;
  pibo_pkg::mask_t pop_mask;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign reg_idx = paddr[pibo_pkg::APB_ADDR_BITS-1:2];
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.periodic <= '0;
      for (int a = 0; a < pibo_pkg::NUM_AXES; a++) begin
        cfg_q.len[a] <= LB'(1);
      end
    end else if (cfg_we) begin
      case (reg_idx)
        pibo_pkg::REG_PERIODIC_X: cfg_q.periodic[0] <= pwdata[0];
        pibo_pkg::REG_PERIODIC_Y: cfg_q.periodic[1] <= pwdata[0];
        pibo_pkg::REG_PERIODIC_Z: cfg_q.periodic[2] <= pwdata[0];
        pibo_pkg::REG_LEN_X:      cfg_q.len[0]      <= pwdata[LB-1:0];
        pibo_pkg::REG_LEN_Y:      cfg_q.len[1]      <= pwdata[LB-1:0];
        pibo_pkg::REG_LEN_Z:      cfg_q.len[2]      <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pibo_pkg::REG_PERIODIC_X: prdata = {{(DW-1){1'b0}}, cfg_q.periodic[0]};
      pibo_pkg::REG_PERIODIC_Y: prdata = {{(DW-1){1'b0}}, cfg_q.periodic[1]};
      pibo_pkg::REG_PERIODIC_Z: prdata = {{(DW-1){1'b0}}, cfg_q.periodic[2]};
      pibo_pkg::REG_LEN_X:      prdata = {{(DW-LB){1'b0}}, cfg_q.len[0]};
      pibo_pkg::REG_LEN_Y:      prdata = {{(DW-LB){1'b0}}, cfg_q.len[1]};
      pibo_pkg::REG_LEN_Z:      prdata = {{(DW-LB){1'b0}}, cfg_q.len[2]};
      default:                  prdata = '0;
    endcase
  end

  // Front end: registers the box pair and evaluates all 26 images at once.
  pibo_front #(
    .DIMENSIONS (DIMENSIONS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_mask_o  (push_mask)
  );

  // Hit masks wait here so that a long drain does not stall the front end.
  pibo_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_mask_i  (push_mask),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_mask_o   (pop_mask)
  );

  // Back end: turns each mask into shift transactions in loop order.
  pibo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_mask_i  (pop_mask),
    .out_o       (out_o)
  );

endmodule
